// ----- hw/rtl/rrts_pkg.sv -----
// Shared types and constants for the round-robin thread scheduler.
package rrts_pkg;

	localparam int unsigned MAX_THREADS_DEF = 64;
	localparam int unsigned OP_W            = 3;
	localparam int unsigned TID_W           = 6;
	localparam int unsigned STATUS_W        = 2;
	localparam int unsigned WORD_W          = 32;
	localparam int unsigned IN_TDATA_W      = 16;
	localparam int unsigned OUT_TDATA_W     = 72;

	typedef enum logic [OP_W-1:0] {
		OP_TICK      = 3'd0,
		OP_SPAWN     = 3'd1,
		OP_TERMINATE = 3'd2,
		OP_BLOCK     = 3'd3,
		OP_RESUME    = 3'd4,
		OP_QUERY     = 3'd5
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_ERR      = 2'd1,
		ST_SHUTDOWN = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PUSH_RUNNING = 2'd0,
		PUSH_TARGET  = 2'd1,
		PUSH_NEW     = 2'd2
	} push_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_PUSH_RUN,
		S_HANDOFF,
		S_SW_RD,
		S_SW_CMP,
		S_SW_END,
		S_HO_QRD,
		S_HO_QWR,
		S_FINISH,
		S_SCAN,
		S_PUSH_NEW,
		S_QRY_RD,
		S_QRY_CAP,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic      ld_cmd;
		logic      sweep_clr;
		logic      sweep_rd;
		logic      sweep_step;
		logic      sweep_fin;
		logic      pop;
		logic      push;
		push_sel_t push_sel;
		logic      scan_clr;
		logic      scan_step;
		logic      q_rd;
		logic      q_rd_next;
		logic      q_inc;
		logic      q_cap;
		logic      spawn_commit;
		logic      term_commit;
		logic      set_blocked;
		logic      clr_blocked;
		logic      soft_reset;
		logic      set_status;
		status_t   status;
		logic      out_load;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            tid_zero;
		logic            live;
		logic            blocked;
		logic            is_running;
		logic            count_zero;
		logic            lc_full;
		logic            entry;
		logic            sweep_done;
		logic            scan_free;
		logic            scan_end;
		logic            found;
		logic            out_free;
		logic            running_live;
	} stat_t;

endpackage

// ----- hw/rtl/round_robin_thread_scheduler_core.sv -----
// Top level of the round-robin thread scheduler.
//
// Channel   Dir  Width  Content
// s_axis    in   16     one command: opcode, thread_id, entry_valid
// m_axis    out  72     one result: status, value, running_thread, total_quanta
//
// One command is in work at a time. A handoff or queue removal walks the ready queue
// memory, reading each entry in S_SW_RD and comparing it in S_SW_CMP, and spawn scans
// the live table one id a cycle. Reset is asynchronous; the state comes up ready with
// no clearing pass. A finished result waits in the output register while the next
// command is taken; a second finished result stalls until that register frees.
module round_robin_thread_scheduler_core import rrts_pkg::*; #(
	parameter int unsigned MAX_THREADS = MAX_THREADS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [2:0] opcode, [8:3] thread_id, [9] entry_valid, [15:10] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [1:0] status, [33:2] value, [39:34] running_thread, [71:40] total_quanta
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	cmd_t  cmd;
	stat_t stat;

	rrts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_axis_tvalid),
		.in_tready (s_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rrts_dp #(.MAX_THREADS(MAX_THREADS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.opcode      (s_axis_tdata[2:0]),
		.thread_id   (s_axis_tdata[8:3]),
		.entry_valid (s_axis_tdata[9]),
		.cmd         (cmd),
		.stat        (stat),
		.out_tvalid  (m_axis_tvalid),
		.out_tready  (m_axis_tready),
		.out_tdata   (m_axis_tdata)
	);

`ifndef ASSERT_OFF
	// One command at a time: ready drops after each transfer
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("scheduler took a second command while busy");

	// The running thread is always a live thread
	a_running_live: assert property (@(posedge clk) disable iff (!arst_n)
		stat.running_live)
		else $error("running thread is not live");

	// Shutdown result shows the state after reset
	a_shutdown: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] == ST_SHUTDOWN) |->
		(m_axis_tdata[39:34] == '0) && (m_axis_tdata[71:40] == 32'd1))
		else $error("shutdown result does not show reset state");
`endif

endmodule

// ----- hw/rtl/rrts_ctrl.sv -----
// Controller state machine of the thread scheduler.
module rrts_ctrl import rrts_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_tvalid,
	output logic  in_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic   pop_q, pop_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pop_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			pop_q   <= pop_d;
		end
	end

	assign in_tready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		pop_d   = pop_q;
		cmd     = '0;
		cmd.pop = pop_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_tvalid) begin
					cmd.ld_cmd = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				unique case (stat.op)
					OP_TICK: state_d = S_PUSH_RUN;
					OP_SPAWN: begin
						if (!stat.entry || stat.lc_full) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_ERR;
						end else begin
							cmd.scan_clr = 1'b1;
							state_d      = S_SCAN;
						end
					end
					OP_TERMINATE: begin
						if (stat.tid_zero) begin
							cmd.soft_reset = 1'b1;
							cmd.set_status = 1'b1;
							cmd.status     = ST_SHUTDOWN;
						end else if (!stat.live) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_ERR;
						end else if (stat.is_running) begin
							state_d = S_HANDOFF;
						end else if (stat.blocked) begin
							state_d = S_FINISH;
						end else begin
							cmd.sweep_clr = 1'b1;
							pop_d         = 1'b0;
							state_d       = S_SW_RD;
						end
					end
					OP_BLOCK: begin
						if (!stat.live || stat.tid_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_ERR;
						end else if (stat.blocked) begin
							state_d = S_DONE;
						end else if (stat.is_running) begin
							state_d = S_HANDOFF;
						end else begin
							cmd.sweep_clr = 1'b1;
							pop_d         = 1'b0;
							state_d       = S_SW_RD;
						end
					end
					OP_RESUME: begin
						if (!stat.live) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_ERR;
						end else if (stat.blocked) begin
							cmd.clr_blocked = 1'b1;
							cmd.push        = 1'b1;
							cmd.push_sel    = PUSH_TARGET;
						end
					end
					OP_QUERY: begin
						if (!stat.live) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_ERR;
						end else begin
							state_d = S_QRY_RD;
						end
					end
					default: begin
						cmd.set_status = 1'b1;
						cmd.status     = ST_ERR;
					end
				endcase
			end
			S_PUSH_RUN: begin
				cmd.push     = 1'b1;
				cmd.push_sel = PUSH_RUNNING;
				state_d      = S_HANDOFF;
			end
			S_HANDOFF: begin
				if (stat.count_zero) begin
					state_d = S_FINISH;
				end else begin
					cmd.sweep_clr = 1'b1;
					pop_d         = 1'b1;
					state_d       = S_SW_RD;
				end
			end
			S_SW_RD: begin
				if (stat.sweep_done) begin
					state_d = S_SW_END;
				end else begin
					cmd.sweep_rd = 1'b1;
					state_d      = S_SW_CMP;
				end
			end
			S_SW_CMP: begin
				cmd.sweep_step = 1'b1;
				state_d        = S_SW_RD;
			end
			S_SW_END: begin
				cmd.sweep_fin = 1'b1;
				state_d       = (pop_q && stat.found) ? S_HO_QRD : S_FINISH;
			end
			S_HO_QRD: begin
				cmd.q_rd      = 1'b1;
				cmd.q_rd_next = 1'b1;
				state_d       = S_HO_QWR;
			end
			S_HO_QWR: begin
				cmd.q_inc = 1'b1;
				state_d   = S_FINISH;
			end
			S_FINISH: begin
				if (stat.op == OP_TERMINATE) cmd.term_commit = 1'b1;
				if (stat.op == OP_BLOCK) cmd.set_blocked = 1'b1;
				state_d = S_DONE;
			end
			S_SCAN: begin
				if (stat.scan_end) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_ERR;
					state_d        = S_DONE;
				end else if (stat.scan_free) begin
					cmd.spawn_commit = 1'b1;
					state_d          = S_PUSH_NEW;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_PUSH_NEW: begin
				cmd.push     = 1'b1;
				cmd.push_sel = PUSH_NEW;
				state_d      = S_DONE;
			end
			S_QRY_RD: begin
				cmd.q_rd = 1'b1;
				state_d  = S_QRY_CAP;
			end
			S_QRY_CAP: begin
				cmd.q_cap = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- hw/rtl/rrts_dp.sv -----
// Datapath of the thread scheduler: thread tables, ready queue, quantum store, result register.
module rrts_dp import rrts_pkg::*; #(
	parameter int unsigned MAX_THREADS = MAX_THREADS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [OP_W-1:0]        opcode,
	input  logic [TID_W-1:0]       thread_id,
	input  logic                   entry_valid,
	input  cmd_t                   cmd,
	output stat_t                  stat,
	output logic                   out_tvalid,
	input  logic                   out_tready,
	output logic [OUT_TDATA_W-1:0] out_tdata
);

	localparam int unsigned ID_W  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_THREADS + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_THREADS);

	// Command item
	logic [OP_W-1:0]  op_q;
	logic [TID_W-1:0] tid_q;
	logic             entry_q;

	// Thread tables and counters
	logic [MAX_THREADS-1:0] live_q, blocked_q, qv_q;
	logic [ID_W-1:0]        running_q, next_q;
	logic [WORD_W-1:0]      total_q, value_q;
	logic [CNT_W-1:0]       lcount_q, count_q, idx_q, scan_q;
	logic                   found_q;
	status_t                status_q;

	// Memories and their read registers
	logic [ID_W-1:0]   fifo_mem [MAX_THREADS];
	logic [ID_W-1:0]   fifo_rd_q;
	logic [WORD_W-1:0] q_mem [MAX_THREADS];
	logic [WORD_W-1:0] q_rd_q;
	logic              qv_rd_q;
	logic [ID_W-1:0]   qaddr_q;

	logic [ID_W-1:0]   tid_idx, scan_idx, push_data, fifo_waddr, q_raddr, q_waddr;
	logic              tid_in, match, fifo_we, q_we, push_ok;
	logic [WORD_W-1:0] qval, q_wdata;

	assign tid_idx  = ID_W'(tid_q);
	assign tid_in   = (32'(tid_q) < 32'(MAX_THREADS));
	assign scan_idx = ID_W'(scan_q);
	assign push_ok  = cmd.push && (count_q < MAX_CNT);
	assign match    = cmd.pop ? (idx_q == '0) : (fifo_rd_q == tid_idx);
	assign qval     = qv_rd_q ? q_rd_q : ((qaddr_q == '0) ? WORD_W'(1) : '0);

	// Status toward the controller
	always_comb begin
		stat.op           = op_q;
		stat.tid_zero     = (tid_q == '0);
		stat.live         = tid_in && live_q[tid_idx];
		stat.blocked      = blocked_q[tid_idx];
		stat.is_running   = tid_in && (tid_idx == running_q);
		stat.count_zero   = (count_q == '0);
		stat.lc_full      = (lcount_q >= MAX_CNT);
		stat.entry        = entry_q;
		stat.sweep_done   = (idx_q == count_q);
		stat.scan_free    = !live_q[scan_idx];
		stat.scan_end     = (scan_q == MAX_CNT);
		stat.found        = found_q;
		stat.out_free     = !out_tvalid || out_tready;
		stat.running_live = live_q[running_q];
	end

	// Select queue write port
	always_comb begin
		unique case (cmd.push_sel)
			PUSH_RUNNING: push_data = running_q;
			PUSH_TARGET:  push_data = tid_idx;
			PUSH_NEW:     push_data = scan_idx;
			default:      push_data = running_q;
		endcase
		fifo_we    = push_ok || (cmd.sweep_step && found_q);
		fifo_waddr = push_ok ? ID_W'(count_q) : ID_W'(idx_q - CNT_W'(1));
	end

	// Ready queue storage: one write, one registered read
	always_ff @(posedge clk) begin
		if (fifo_we) fifo_mem[fifo_waddr] <= push_ok ? push_data : fifo_rd_q;
		if (cmd.sweep_rd) fifo_rd_q <= fifo_mem[ID_W'(idx_q)];
	end

	// Select quantum store ports
	always_comb begin
		q_raddr = cmd.q_rd_next ? next_q : tid_idx;
		q_we    = cmd.q_inc || cmd.spawn_commit;
		q_waddr = cmd.q_inc ? next_q : scan_idx;
		q_wdata = cmd.q_inc ? (qval + WORD_W'(1)) : '0;
	end

	// Quantum store
	always_ff @(posedge clk) begin
		if (q_we) q_mem[q_waddr] <= q_wdata;
		if (cmd.q_rd) begin
			q_rd_q  <= q_mem[q_raddr];
			qv_rd_q <= qv_q[q_raddr];
			qaddr_q <= q_raddr;
		end
	end

	// Hold the command item
	always_ff @(posedge clk) begin
		if (cmd.ld_cmd) begin
			op_q    <= opcode;
			tid_q   <= thread_id;
			entry_q <= entry_valid;
		end
	end

	// Scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= MAX_THREADS'(1);
			blocked_q <= '0;
			qv_q      <= '0;
			running_q <= '0;
			total_q   <= WORD_W'(1);
			lcount_q  <= CNT_W'(1);
			count_q   <= '0;
			idx_q     <= '0;
			scan_q    <= '0;
			found_q   <= 1'b0;
			next_q    <= '0;
			status_q  <= ST_OK;
			value_q   <= '0;
		end else begin
			if (cmd.ld_cmd) begin
				status_q <= ST_OK;
				value_q  <= '0;
			end
			if (cmd.set_status) status_q <= cmd.status;
			if (cmd.soft_reset) begin
				live_q    <= MAX_THREADS'(1);
				blocked_q <= '0;
				qv_q      <= '0;
				running_q <= '0;
				total_q   <= WORD_W'(1);
				lcount_q  <= CNT_W'(1);
				count_q   <= '0;
			end else begin
				if (push_ok) count_q <= count_q + CNT_W'(1);
				if (cmd.sweep_fin && found_q) count_q <= count_q - CNT_W'(1);
				if (cmd.q_inc) begin
					running_q        <= next_q;
					total_q          <= total_q + WORD_W'(1);
					qv_q[next_q]     <= 1'b1;
				end
				if (cmd.spawn_commit) begin
					live_q[scan_idx]    <= 1'b1;
					blocked_q[scan_idx] <= 1'b0;
					qv_q[scan_idx]      <= 1'b1;
					lcount_q            <= lcount_q + CNT_W'(1);
					value_q             <= WORD_W'(scan_q);
				end
				if (cmd.term_commit) begin
					live_q[tid_idx]    <= 1'b0;
					blocked_q[tid_idx] <= 1'b0;
					lcount_q           <= lcount_q - CNT_W'(1);
				end
				if (cmd.set_blocked) blocked_q[tid_idx] <= 1'b1;
				if (cmd.clr_blocked) blocked_q[tid_idx] <= 1'b0;
			end
			if (cmd.q_cap) value_q <= qval;
			// Walk the queue: find the entry, then shift the rest down one place
			if (cmd.sweep_clr) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			if (cmd.sweep_step) begin
				idx_q <= idx_q + CNT_W'(1);
				if (!found_q && match) begin
					found_q <= 1'b1;
					if (cmd.pop) next_q <= fifo_rd_q;
				end
			end
			if (cmd.scan_clr) scan_q <= CNT_W'(1);
			if (cmd.scan_step) scan_q <= scan_q + CNT_W'(1);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_tvalid <= 1'b0;
		end else if (cmd.out_load) begin
			out_tvalid <= 1'b1;
		end else if (out_tready) begin
			out_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) out_tdata <= {total_q, TID_W'(running_q), value_q, status_q};
	end

endmodule

// ----- test/round_robin_thread_scheduler_core_tb.sv -----
// Testbench for the round-robin thread scheduler core: directed and random commands against a predictor.
`timescale 1ns / 100ps

module round_robin_thread_scheduler_core_tb;
	import rrts_pkg::*;

	localparam int NT = 64;
	localparam int LIMIT = 2000000;

	typedef struct packed {
		logic [2:0] op;
		logic [5:0] tid;
		logic       entry;
	} cmd_item_t;

	// Packed from the top bit down: total_quanta high, status low
	typedef struct packed {
		logic [31:0] total;
		logic [5:0]  running;
		logic [31:0] value;
		logic [1:0]  status;
	} sched_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	round_robin_thread_scheduler_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Predictor state
	bit          p_live[NT];
	bit          p_blocked[NT];
	logic [31:0] p_quanta[NT];
	logic [5:0]  p_fifo[$];
	logic [5:0]  p_running;
	logic [31:0] p_total;
	int          p_live_count;

	cmd_item_t     pending_cmds[$];
	sched_result_t expected_results[$];
	int  errors = 0;
	int  cycles = 0;
	int  sent = 0;
	int  got = 0;
	bit  hold_on = 0;     // long receiver hold-off request
	bit  drain_req = 0;   // sender pause until empty
	int  n_shutdown = 0;

	initial forever #5 clk = ~clk;

	task automatic sched_reset();
		for (int i = 0; i < NT; i++) begin
			p_live[i] = 0;
			p_blocked[i] = 0;
			p_quanta[i] = '0;
		end
		p_live[0] = 1;
		p_quanta[0] = 32'd1;
		p_fifo.delete();
		p_running = '0;
		p_total = 32'd1;
		p_live_count = 1;
	endtask

	task automatic fifo_drop(input logic [5:0] id);
		for (int i = 0; i < p_fifo.size(); i++) begin
			if (p_fifo[i] == id) begin
				p_fifo.delete(i);
				return;
			end
		end
	endtask

	task automatic fifo_add(input logic [5:0] id);
		if (p_fifo.size() < NT)
			p_fifo.push_back(id);
	endtask

	task automatic cpu_handoff();
		logic [5:0] nxt;
		if (p_fifo.size() == 0)
			return;
		nxt = p_fifo[0];
		p_fifo.delete(0);
		p_running = nxt;
		p_total = p_total + 32'd1;
		p_quanta[nxt] = p_quanta[nxt] + 32'd1;
	endtask

	// Compute the result of one command and advance the predictor
	task automatic schedule_cmd(input cmd_item_t c);
		sched_result_t r;
		bit live;
		int id;
		r.status = ST_OK;
		r.value = '0;
		live = p_live[c.tid];
		case (c.op)
			OP_TICK: begin
				fifo_add(p_running);
				cpu_handoff();
			end
			OP_SPAWN: begin
				if (!c.entry || p_live_count >= NT) begin
					r.status = ST_ERR;
				end else begin
					for (id = 1; id < NT; id++)
						if (!p_live[id]) break;
					if (id >= NT) begin
						r.status = ST_ERR;
					end else begin
						p_live[id] = 1;
						p_blocked[id] = 0;
						p_quanta[id] = '0;
						p_live_count++;
						fifo_add(id[5:0]);
						r.value = 32'(id);
					end
				end
			end
			OP_TERMINATE: begin
				if (c.tid == 0) begin
					sched_reset();
					r.status = ST_SHUTDOWN;
					n_shutdown++;
				end else if (!live) begin
					r.status = ST_ERR;
				end else begin
					if (c.tid == p_running) cpu_handoff();
					else if (p_blocked[c.tid]) p_blocked[c.tid] = 0;
					else fifo_drop(c.tid);
					p_live[c.tid] = 0;
					p_blocked[c.tid] = 0;
					p_live_count--;
				end
			end
			OP_BLOCK: begin
				if (!live || c.tid == 0) begin
					r.status = ST_ERR;
				end else if (!p_blocked[c.tid]) begin
					if (c.tid == p_running) cpu_handoff();
					else fifo_drop(c.tid);
					p_blocked[c.tid] = 1;
				end
			end
			OP_RESUME: begin
				if (!live) begin
					r.status = ST_ERR;
				end else if (p_blocked[c.tid]) begin
					p_blocked[c.tid] = 0;
					fifo_add(c.tid);
				end
			end
			OP_QUERY: begin
				if (!live) r.status = ST_ERR;
				else r.value = p_quanta[c.tid];
			end
			default: r.status = ST_ERR;
		endcase
		r.running = p_running;
		r.total = p_total;
		expected_results.push_back(r);
	endtask

	function automatic cmd_item_t mk(input logic [2:0] op, input logic [5:0] tid,
			input logic entry);
		cmd_item_t c;
		c.op = op;
		c.tid = tid;
		c.entry = entry;
		return c;
	endfunction

	// Pick a live thread id, else a random one
	function automatic logic [5:0] pick_tid();
		int tries;
		logic [5:0] t;
		for (tries = 0; tries < 8; tries++) begin
			t = 6'($urandom_range(1, NT - 1));
			if (p_live[t]) return t;
		end
		return 6'($urandom_range(0, NT - 1));
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got_v,
			input logic [31:0] exp_v);
		errors++;
		$display("mismatch %s at result %0d: got %0h, expected %0h", what, got, got_v, exp_v);
	endtask

	// Driver: draw a gap per item, then offer it until the transfer
	int gap_left = 0;
	bit gap_drawn = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				schedule_cmd(pending_cmds[0]);
				pending_cmds.delete(0);
				sent++;
				gap_drawn = 0;
			end
			if (!gap_drawn && pending_cmds.size() > 0) begin
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
				gap_drawn = 1;
			end
			if (drain_req && expected_results.size() != 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (gap_drawn && gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (gap_drawn && pending_cmds.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {6'd0, pending_cmds[0].entry, pending_cmds[0].tid,
					pending_cmds[0].op};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: check each transfer, then draw the receiver's stall
	int stall_left = 0;
	always @(posedge clk) begin
		sched_result_t r, e;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				r = m_axis_tdata;
				if (expected_results.size() == 0) begin
					errors++;
					$display("unexpected result %0h", m_axis_tdata);
				end else begin
					e = expected_results[0];
					expected_results.delete(0);
					if (r.status !== e.status)
						report_mismatch("status", 32'(r.status), 32'(e.status));
					if (r.value !== e.value) report_mismatch("value", r.value, e.value);
					if (r.running !== e.running)
						report_mismatch("running_thread", 32'(r.running), 32'(e.running));
					if (r.total !== e.total) report_mismatch("total_quanta", r.total, e.total);
				end
				got++;
				stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
			end
			if (hold_on) begin
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Receiver hold-off, counted in cycles in its own process
	initial begin
		wait (sent >= 300);
		hold_on = 1;
		repeat (600) @(posedge clk);
		hold_on = 0;
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	// Random command with mostly well-formed activity
	function automatic cmd_item_t rand_cmd();
		int k;
		k = $urandom_range(0, 99);
		if (k < 25) return mk(OP_TICK, 6'($urandom), 1'($urandom));
		if (k < 45) return mk(OP_SPAWN, 6'($urandom), ($urandom_range(0, 9) != 0));
		if (k < 55) return mk(OP_TERMINATE, ($urandom_range(0, 40) == 0) ? 6'd0 : pick_tid(),
			1'($urandom));
		if (k < 70) return mk(OP_BLOCK, ($urandom_range(0, 15) == 0) ? 6'd0 : pick_tid(),
			1'($urandom));
		if (k < 85) return mk(OP_RESUME, pick_tid(), 1'($urandom));
		if (k < 97) return mk(OP_QUERY, ($urandom_range(0, 7) == 0) ? 6'd0 : pick_tid(),
			1'($urandom));
		return mk(3'($urandom_range(6, 7)), 6'($urandom), 1'($urandom));
	endfunction

	initial begin
		sched_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: errors, each operation, extremes, shutdown
		pending_cmds.push_back(mk(OP_TICK, 6'd0, 1'b0));
		pending_cmds.push_back(mk(OP_SPAWN, 6'd63, 1'b0));
		pending_cmds.push_back(mk(OP_SPAWN, 6'd0, 1'b1));
		pending_cmds.push_back(mk(OP_SPAWN, 6'd0, 1'b1));
		pending_cmds.push_back(mk(OP_QUERY, 6'd0, 1'b0));
		pending_cmds.push_back(mk(OP_QUERY, 6'd63, 1'b1));
		pending_cmds.push_back(mk(OP_TICK, 6'd0, 1'b0));
		pending_cmds.push_back(mk(OP_BLOCK, 6'd0, 1'b0));
		pending_cmds.push_back(mk(OP_BLOCK, 6'd1, 1'b0));
		pending_cmds.push_back(mk(OP_BLOCK, 6'd1, 1'b0));
		pending_cmds.push_back(mk(OP_BLOCK, 6'd2, 1'b0));
		pending_cmds.push_back(mk(OP_RESUME, 6'd0, 1'b0));
		pending_cmds.push_back(mk(OP_RESUME, 6'd1, 1'b0));
		pending_cmds.push_back(mk(OP_TICK, 6'd0, 1'b0));
		pending_cmds.push_back(mk(OP_TERMINATE, 6'd1, 1'b0));
		pending_cmds.push_back(mk(OP_TERMINATE, 6'd2, 1'b0));
		pending_cmds.push_back(mk(OP_TERMINATE, 6'd63, 1'b0));
		pending_cmds.push_back(mk(OP_RESUME, 6'd63, 1'b0));
		pending_cmds.push_back(mk(3'd6, 6'd63, 1'b1));
		pending_cmds.push_back(mk(3'd7, 6'd0, 1'b0));
		pending_cmds.push_back(mk(OP_SPAWN, 6'd0, 1'b1));
		pending_cmds.push_back(mk(OP_TERMINATE, 6'd0, 1'b0));
		pending_cmds.push_back(mk(OP_QUERY, 6'd1, 1'b0));
		wait (pending_cmds.size() == 0 && expected_results.size() == 0);

		// Fill the table to its limit, then tick the long queue around
		for (int i = 0; i < 64; i++) pending_cmds.push_back(mk(OP_SPAWN, 6'd0, 1'b1));
		for (int i = 0; i < 70; i++) pending_cmds.push_back(mk(OP_TICK, 6'd0, 1'b0));
		pending_cmds.push_back(mk(OP_BLOCK, 6'd63, 1'b0));
		pending_cmds.push_back(mk(OP_TERMINATE, 6'd62, 1'b0));
		pending_cmds.push_back(mk(OP_QUERY, 6'd63, 1'b0));
		wait (pending_cmds.size() == 0);

		// Pause the sender until the block has drained
		drain_req = 1;
		wait (expected_results.size() == 0);
		drain_req = 0;

		// Random phase, generated one ahead so pick_tid sees current state
		for (int n = 0; n < 1150; n++) begin
			wait (pending_cmds.size() == 0);
			pending_cmds.push_back(rand_cmd());
			@(posedge clk);
		end
		wait (pending_cmds.size() == 0);
		wait (expected_results.size() == 0);
		repeat (300) @(posedge clk);

		$display("ran %0d commands, %0d results, %0d shutdowns", sent, got, n_shutdown);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("errors: %0d, left over: %0d", errors, expected_results.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule
